>>> hw/rtl/rvcam_pkg.sv
// types and constants shared by the rail voltage and current alert monitor
`timescale 1ns / 1ps
`default_nettype none

package rvcam_pkg;

   // current hysteresis half-width in milliamps
   localparam int CURRENT_HYST_MA = 10;

   // widths of the comparison arithmetic
   localparam int VOLT_SUM_W = 18;
   localparam int CURR_SUM_W = 18;

   // alert flag bit positions
   localparam int FLAG_OVA   = 0;
   localparam int FLAG_UVA   = 1;
   localparam int FLAG_OCA   = 2;
   localparam int FLAG_UCA   = 3;
   localparam int FLAG_OVW   = 4;
   localparam int FLAG_UVW   = 5;
   localparam int FLAG_OCW   = 6;
   localparam int FLAG_UCW   = 7;
   localparam int FLAG_FAULT = 8;
   localparam int FLAG_W     = 9;

   // power good codes
   localparam logic [1:0] PG_UNKNOWN  = 2'd0;
   localparam logic [1:0] PG_NOT_GOOD = 2'd1;
   localparam logic [1:0] PG_GOOD     = 2'd2;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_NOMINAL_MV     = 3'd0,
      REG_V_ALERT_DEV_MV = 3'd1,
      REG_V_WARN_DEV_MV  = 3'd2,
      REG_V_HYST_MV      = 3'd3,
      REG_OC_ALERT_MA    = 3'd4,
      REG_OC_WARN_MA     = 3'd5,
      REG_UC_WARN_MA     = 3'd6,
      REG_UC_ALERT_MA    = 3'd7
   } reg_index_type;

   localparam int CSR_ADDR_W = 5;

   // configuration register set
   typedef struct packed {
      logic        [15:0] nominal_mv;
      logic        [15:0] v_alert_dev_mv;
      logic        [15:0] v_warn_dev_mv;
      logic        [15:0] v_hyst_mv;
      logic signed [15:0] oc_alert_ma;
      logic signed [15:0] oc_warn_ma;
      logic signed [15:0] uc_warn_ma;
      logic signed [15:0] uc_alert_ma;
   } cfg_type;

   // one input sample
   typedef struct packed {
      logic        [15:0] voltage_mv;
      logic               voltage_valid;
      logic signed [15:0] current_ma;
      logic               current_valid;
      logic        [1:0]  hw_power_good;
      logic               rail_active;
   } req_type;

   // one result
   typedef struct packed {
      logic [FLAG_W-1:0] alert_flags;
      logic              is_alert;
      logic [1:0]        sw_power_good;
   } rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/rail_voltage_current_alert_monitor.sv
// rail voltage and current alert monitor: window comparators with hysteresis
// a sample goes through the input stage register and the compare into the result register
// one sample per cycle unless rsp_stall holds; the flag update is a single compare stage
// reset clears the flags, the power good state (unknown) and both valid bits;
// thresholds return to their defaults and voltage checking is off
`timescale 1ns / 1ps
`default_nettype none

module rail_voltage_current_alert_monitor (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  rvcam_pkg::req_type                    req_data,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output rvcam_pkg::rsp_type                    rsp_data,
   input  wire                                   csr_psel,
   input  wire                                   csr_penable,
   input  wire                                   csr_pwrite,
   input  wire  [rvcam_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire  [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);

   localparam int VW = rvcam_pkg::VOLT_SUM_W;
   localparam int CW = rvcam_pkg::CURR_SUM_W;
   localparam logic signed [CW-1:0] CURR_HYST = CW'(rvcam_pkg::CURRENT_HYST_MA);

   rvcam_pkg::cfg_type                  cfg_ff, cfg_in;
   logic                                s1_valid_ff, s1_valid_in;
   rvcam_pkg::req_type                  s1_item_ff, s1_item_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   rvcam_pkg::rsp_type                  rsp_data_ff, rsp_data_in;
   logic [rvcam_pkg::FLAG_W-1:0]        flag_ff, flag_in;
   logic [1:0]                          sw_good_ff, sw_good_in;

   logic                                csr_write;
   rvcam_pkg::reg_index_type            csr_index;
   logic                                out_go;
   logic                                s1_move;
   logic                                req_take;

   logic [rvcam_pkg::FLAG_W-1:0]        set_bits;
   logic [rvcam_pkg::FLAG_W-1:0]        clr_bits;
   logic [1:0]                          ova_res, ovw_res, uva_res, uvw_res;
   logic [1:0]                          oca_res, ocw_res, uca_res, ucw_res;
   logic [VW-1:0]                       v_ext, vn_ext, vh_ext;
   logic signed [CW-1:0]                i_ext;

   // over-voltage window: {set, clear}, all sums non-negative
   function automatic logic [1:0] volt_over(input logic [VW-1:0] v,
                                            input logic [VW-1:0] vn,
                                            input logic [VW-1:0] dev,
                                            input logic [VW-1:0] h);
      logic [VW-1:0] thr;
      thr = vn + dev;
      volt_over = {(v > thr + h), (v + h < thr)};
   endfunction

   // under-voltage window: {set, clear}, terms moved so nothing goes negative
   function automatic logic [1:0] volt_under(input logic [VW-1:0] v,
                                             input logic [VW-1:0] vn,
                                             input logic [VW-1:0] dev,
                                             input logic [VW-1:0] h);
      volt_under = {(v + dev + h < vn), (v + dev > vn + h)};
   endfunction

   // over-current window: {set, clear}
   function automatic logic [1:0] curr_over(input logic signed [CW-1:0] i,
                                            input logic signed [15:0]   thr);
      logic signed [CW-1:0] t;
      t = CW'(thr);
      curr_over = {(i > t + CURR_HYST), (i < t - CURR_HYST)};
   endfunction

   // under-current window: {set, clear}
   function automatic logic [1:0] curr_under(input logic signed [CW-1:0] i,
                                             input logic signed [15:0]   thr);
      logic signed [CW-1:0] t;
      t = CW'(thr);
      curr_under = {(i < t - CURR_HYST), (i > t + CURR_HYST)};
   endfunction

   // configuration port decode
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = rvcam_pkg::reg_index_type'(csr_paddr[rvcam_pkg::CSR_ADDR_W-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            rvcam_pkg::REG_NOMINAL_MV:     cfg_in.nominal_mv     = csr_pwdata[15:0];
            rvcam_pkg::REG_V_ALERT_DEV_MV: cfg_in.v_alert_dev_mv = csr_pwdata[15:0];
            rvcam_pkg::REG_V_WARN_DEV_MV:  cfg_in.v_warn_dev_mv  = csr_pwdata[15:0];
            rvcam_pkg::REG_V_HYST_MV:      cfg_in.v_hyst_mv      = csr_pwdata[15:0];
            rvcam_pkg::REG_OC_ALERT_MA:    cfg_in.oc_alert_ma    = csr_pwdata[15:0];
            rvcam_pkg::REG_OC_WARN_MA:     cfg_in.oc_warn_ma     = csr_pwdata[15:0];
            rvcam_pkg::REG_UC_WARN_MA:     cfg_in.uc_warn_ma     = csr_pwdata[15:0];
            rvcam_pkg::REG_UC_ALERT_MA:    cfg_in.uc_alert_ma    = csr_pwdata[15:0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   // register read mux
   always_comb begin
      case (csr_index)
         rvcam_pkg::REG_NOMINAL_MV:     csr_prdata = {16'd0, cfg_ff.nominal_mv};
         rvcam_pkg::REG_V_ALERT_DEV_MV: csr_prdata = {16'd0, cfg_ff.v_alert_dev_mv};
         rvcam_pkg::REG_V_WARN_DEV_MV:  csr_prdata = {16'd0, cfg_ff.v_warn_dev_mv};
         rvcam_pkg::REG_V_HYST_MV:      csr_prdata = {16'd0, cfg_ff.v_hyst_mv};
         rvcam_pkg::REG_OC_ALERT_MA:    csr_prdata = {16'd0, cfg_ff.oc_alert_ma};
         rvcam_pkg::REG_OC_WARN_MA:     csr_prdata = {16'd0, cfg_ff.oc_warn_ma};
         rvcam_pkg::REG_UC_WARN_MA:     csr_prdata = {16'd0, cfg_ff.uc_warn_ma};
         rvcam_pkg::REG_UC_ALERT_MA:    csr_prdata = {16'd0, cfg_ff.uc_alert_ma};
         default:                       csr_prdata = 32'd0;
      endcase
   end

   // pipeline flow: the input stage moves on when the result register is free
   assign out_go    = ~rsp_valid_ff | ~rsp_stall;
   assign s1_move   = s1_valid_ff & out_go;
   assign req_stall = s1_valid_ff & ~out_go;
   assign req_take  = req_valid & ~req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_item_in  = req_data;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   // window comparisons on the registered sample
   always_comb begin
      v_ext  = VW'(s1_item_ff.voltage_mv);
      vn_ext = VW'(cfg_ff.nominal_mv);
      vh_ext = VW'(cfg_ff.v_hyst_mv);
      i_ext  = CW'(s1_item_ff.current_ma);

      ova_res = volt_over (v_ext, vn_ext, VW'(cfg_ff.v_alert_dev_mv), vh_ext);
      ovw_res = volt_over (v_ext, vn_ext, VW'(cfg_ff.v_warn_dev_mv),  vh_ext);
      uva_res = volt_under(v_ext, vn_ext, VW'(cfg_ff.v_alert_dev_mv), vh_ext);
      uvw_res = volt_under(v_ext, vn_ext, VW'(cfg_ff.v_warn_dev_mv),  vh_ext);
      oca_res = curr_over (i_ext, cfg_ff.oc_alert_ma);
      ocw_res = curr_over (i_ext, cfg_ff.oc_warn_ma);
      uca_res = curr_under(i_ext, cfg_ff.uc_alert_ma);
      ucw_res = curr_under(i_ext, cfg_ff.uc_warn_ma);
   end

   // set and clear masks, then the flag and power good update
   always_comb begin
      set_bits = '0;
      clr_bits = '0;
      if ((cfg_ff.nominal_mv != 16'd0) && s1_item_ff.voltage_valid) begin
         {set_bits[rvcam_pkg::FLAG_OVA], clr_bits[rvcam_pkg::FLAG_OVA]} = ova_res;
         {set_bits[rvcam_pkg::FLAG_OVW], clr_bits[rvcam_pkg::FLAG_OVW]} = ovw_res;
         {set_bits[rvcam_pkg::FLAG_UVA], clr_bits[rvcam_pkg::FLAG_UVA]} = uva_res;
         {set_bits[rvcam_pkg::FLAG_UVW], clr_bits[rvcam_pkg::FLAG_UVW]} = uvw_res;
      end
      if (s1_item_ff.current_valid) begin
         {set_bits[rvcam_pkg::FLAG_OCA], clr_bits[rvcam_pkg::FLAG_OCA]} = oca_res;
         {set_bits[rvcam_pkg::FLAG_OCW], clr_bits[rvcam_pkg::FLAG_OCW]} = ocw_res;
         {set_bits[rvcam_pkg::FLAG_UCA], clr_bits[rvcam_pkg::FLAG_UCA]} = uca_res;
         {set_bits[rvcam_pkg::FLAG_UCW], clr_bits[rvcam_pkg::FLAG_UCW]} = ucw_res;
      end
      // inactive rail drops the current and under-voltage flags; over-voltage and fault stay
      if (!s1_item_ff.rail_active) begin
         clr_bits[rvcam_pkg::FLAG_OCA] = 1'b1;
         clr_bits[rvcam_pkg::FLAG_OCW] = 1'b1;
         clr_bits[rvcam_pkg::FLAG_UCA] = 1'b1;
         clr_bits[rvcam_pkg::FLAG_UCW] = 1'b1;
         clr_bits[rvcam_pkg::FLAG_UVA] = 1'b1;
         clr_bits[rvcam_pkg::FLAG_UVW] = 1'b1;
      end
      if (s1_item_ff.hw_power_good == rvcam_pkg::PG_NOT_GOOD) begin
         set_bits[rvcam_pkg::FLAG_FAULT] = 1'b1;
      end else if (s1_item_ff.hw_power_good == rvcam_pkg::PG_GOOD) begin
         clr_bits[rvcam_pkg::FLAG_FAULT] = 1'b1;
      end

      flag_in    = flag_ff;
      sw_good_in = sw_good_ff;
      if (s1_move) begin
         flag_in = (flag_ff | set_bits) & ~clr_bits;
         if (cfg_ff.nominal_mv != 16'd0) begin
            sw_good_in = (set_bits[rvcam_pkg::FLAG_OVA] | set_bits[rvcam_pkg::FLAG_UVA]) ?
                         rvcam_pkg::PG_NOT_GOOD : rvcam_pkg::PG_GOOD;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_move) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.alert_flags   = flag_in;
         rsp_data_in.is_alert      = flag_in[rvcam_pkg::FLAG_OVA] | flag_in[rvcam_pkg::FLAG_UVA] |
                                     flag_in[rvcam_pkg::FLAG_OCA] | flag_in[rvcam_pkg::FLAG_UCA] |
                                     flag_in[rvcam_pkg::FLAG_FAULT];
         rsp_data_in.sw_power_good = sw_good_in;
      end else if (out_go) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.nominal_mv     <= 16'd0;
         cfg_ff.v_alert_dev_mv <= 16'd0;
         cfg_ff.v_warn_dev_mv  <= 16'd0;
         cfg_ff.v_hyst_mv      <= 16'd0;
         cfg_ff.oc_alert_ma    <= 16'sh7FFF;
         cfg_ff.oc_warn_ma     <= 16'sh7FFF;
         cfg_ff.uc_warn_ma     <= 16'sh8000;
         cfg_ff.uc_alert_ma    <= 16'sh8000;
         s1_valid_ff           <= 1'b0;
         rsp_valid_ff          <= 1'b0;
         flag_ff               <= '0;
         sw_good_ff            <= rvcam_pkg::PG_UNKNOWN;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         flag_ff      <= flag_in;
         sw_good_ff   <= sw_good_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
